>>> rtl/dur_pkg.sv
// Shared types, codes and bit positions of the dual UART register block.
`default_nettype none
package dur_pkg;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 5;
  localparam int BYTE_W   = 8;
  localparam int RDATA_W  = 16;
  localparam int IRQ_W    = 2;
  localparam int CNT_W    = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Item kinds.
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

  // Interrupt line requests.
  localparam logic [IRQ_W-1:0] IRQ_NONE  = 2'd0;
  localparam logic [IRQ_W-1:0] IRQ_RAISE = 2'd1;
  localparam logic [IRQ_W-1:0] IRQ_LOWER = 2'd2;

  // Register numbers.
  localparam logic [ADDR_W-1:0] REG_MR_A  = 5'd0;
  localparam logic [ADDR_W-1:0] REG_SR_A  = 5'd1;
  localparam logic [ADDR_W-1:0] REG_CR_A  = 5'd2;
  localparam logic [ADDR_W-1:0] REG_BUF_A = 5'd3;
  localparam logic [ADDR_W-1:0] REG_ACR   = 5'd4;
  localparam logic [ADDR_W-1:0] REG_ISR   = 5'd5;
  localparam logic [ADDR_W-1:0] REG_CTU   = 5'd6;
  localparam logic [ADDR_W-1:0] REG_CTL   = 5'd7;
  localparam logic [ADDR_W-1:0] REG_MR_B  = 5'd8;
  localparam logic [ADDR_W-1:0] REG_SR_B  = 5'd9;
  localparam logic [ADDR_W-1:0] REG_CR_B  = 5'd10;
  localparam logic [ADDR_W-1:0] REG_BUF_B = 5'd11;
  localparam logic [ADDR_W-1:0] REG_START = 5'd14;
  localparam logic [ADDR_W-1:0] REG_STOP  = 5'd15;

  // Configuration register byte addresses.
  localparam logic [PADDR_W-1:0] CFG_COUNTER_STEP = 3'd0;
  localparam logic [CNT_W-1:0]   COUNTER_STEP_RST = 16'd1;

  // Status bits.
  localparam int ST_RXR = 0;
  localparam int ST_TXR = 2;
  localparam int ST_TXE = 3;
  localparam logic [BYTE_W-1:0] ST_ERR_MASK = 8'h70;

  // Command bits and miscellaneous command codes.
  localparam int CM_ERX = 0;
  localparam int CM_DRX = 1;
  localparam int CM_ETX = 2;
  localparam int CM_DTX = 3;
  localparam logic [2:0] MISC_RESET_MR = 3'd1;
  localparam logic [2:0] MISC_RESET_RX = 3'd2;
  localparam logic [2:0] MISC_RESET_TX = 3'd3;
  localparam logic [2:0] MISC_RESET_ER = 3'd4;

  // Interrupt status bits.
  localparam int IS_CRI = 3;
  localparam logic [BYTE_W-1:0] TX_INT_BIT [2] = '{8'h01, 8'h10};
  localparam logic [BYTE_W-1:0] RX_INT_BIT [2] = '{8'h02, 8'h20};

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   reg_addr;
    logic [BYTE_W-1:0]   write_data;
    logic                rx_valid;
    logic [BYTE_W-1:0]   rx_char;
    logic                pir9_enable;
  } item_t;

  typedef struct packed {
    logic [RDATA_W-1:0] read_data;
    logic [IRQ_W-1:0]   irq_action;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_char;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/dur_if.sv
// Item and result channel interfaces of the dual UART register block.
`default_nettype none
interface dur_item_if;
  import dur_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   reg_addr;
  logic [BYTE_W-1:0]   write_data;
  logic                rx_valid;
  logic [BYTE_W-1:0]   rx_char;
  logic                pir9_enable;

  modport source (output valid, action, reg_addr, write_data, rx_valid, rx_char,
                  pir9_enable, input ready);
  modport sink (input valid, action, reg_addr, write_data, rx_valid, rx_char,
                pir9_enable, output ready);
endinterface

interface dur_result_if;
  import dur_pkg::*;
  logic               valid;
  logic               ready;
  logic [RDATA_W-1:0] read_data;
  logic [IRQ_W-1:0]   irq_action;
  logic               tx_valid;
  logic [BYTE_W-1:0]  tx_char;

  modport source (output valid, read_data, irq_action, tx_valid, tx_char, input ready);
  modport sink (input valid, read_data, irq_action, tx_valid, tx_char, output ready);
endinterface
`default_nettype wire

>>> rtl/dur_cfg.sv
// APB configuration register holding the counter step.
`default_nettype none
module dur_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dur_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dur_pkg::PDATA_W-1:0] pwdata,
  output logic      [dur_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output logic      [dur_pkg::CNT_W-1:0]   counter_step
);
  import dur_pkg::*;

  logic hit;

  // Only the word at offset zero is decoded; byte offset bits are ignored.
  assign hit    = (paddr[PADDR_W-1] == CFG_COUNTER_STEP[PADDR_W-1]);
  assign pready = 1'b1;
  assign prdata = hit ? {{(PDATA_W-CNT_W){1'b0}}, counter_step} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_step <= COUNTER_STEP_RST;
    end else if (psel && penable && pwrite && hit) begin
      counter_step <= pwdata[CNT_W-1:0];
    end
  end
endmodule
`default_nettype wire

>>> rtl/dur_core.sv
// Register file state of both channels, interrupt logic and counter, updated once per item.
`default_nettype none
module dur_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire dur_pkg::item_t            item,
  input  wire logic [dur_pkg::CNT_W-1:0] counter_step,
  output dur_pkg::result_t               res
);
  import dur_pkg::*;

  logic [BYTE_W-1:0] mode [4];
  logic [1:0]        mode_sel;
  logic [BYTE_W-1:0] status [2];
  logic [BYTE_W-1:0] command [2];
  logic [BYTE_W-1:0] rbuf [2];
  logic [BYTE_W-1:0] int_status;
  logic [BYTE_W-1:0] int_mask;
  logic [BYTE_W-1:0] aux_control;
  logic [CNT_W-1:0]  counter_preset;
  logic [CNT_W-1:0]  counter_value;
  logic              counter_running;

  logic [BYTE_W-1:0] mode_next [4];
  logic [1:0]        mode_sel_next;
  logic [BYTE_W-1:0] status_next [2];
  logic [BYTE_W-1:0] command_next [2];
  logic [BYTE_W-1:0] rbuf_next [2];
  logic [BYTE_W-1:0] int_status_next;
  logic [BYTE_W-1:0] int_mask_next;
  logic [BYTE_W-1:0] aux_control_next;
  logic [CNT_W-1:0]  counter_preset_next;
  logic [CNT_W-1:0]  counter_value_next;
  logic              counter_running_next;

  logic       sel_b;
  logic       tx_refresh;
  logic [2:0] misc;

  assign sel_b = item.reg_addr[3];
  assign misc  = item.write_data[6:4];

  always_comb begin
    mode_next            = mode;
    mode_sel_next        = mode_sel;
    status_next          = status;
    command_next         = command;
    rbuf_next            = rbuf;
    int_status_next      = int_status;
    int_mask_next        = int_mask;
    aux_control_next     = aux_control;
    counter_preset_next  = counter_preset;
    counter_value_next   = counter_value;
    counter_running_next = counter_running;
    tx_refresh           = 1'b0;
    res                  = '0;
    res.irq_action       = IRQ_NONE;

    unique case (item.action)
      ACT_READ: begin
        unique case (item.reg_addr)
          REG_MR_A, REG_MR_B: begin
            for (int c = 0; c < 2; c++) begin
              if (sel_b == c[0]) begin
                res.read_data = {8'h00, mode_sel[c] ? mode[2*c+1] : mode[2*c]};
                mode_sel_next[c] = ~mode_sel[c];
              end
            end
          end
          REG_SR_A: begin
            res.read_data = {8'h00, status[0]};
            status_next[0][ST_RXR] = 1'b0;
          end
          REG_SR_B: res.read_data = {8'h00, status[1]};
          REG_BUF_A, REG_BUF_B: begin
            for (int c = 0; c < 2; c++) begin
              if (sel_b == c[0]) begin
                res.read_data = {status[c], rbuf[c]};
                status_next[c][ST_RXR] = 1'b0;
                int_status_next = int_status & ~RX_INT_BIT[c];
              end
            end
          end
          REG_ISR:   res.read_data = {8'h00, int_status};
          REG_START: counter_running_next = 1'b1;
          REG_STOP: begin
            counter_running_next = 1'b0;
            int_status_next[IS_CRI] = 1'b0;
          end
          default: ;
        endcase
      end

      ACT_WRITE: begin
        unique case (item.reg_addr)
          REG_MR_A, REG_MR_B: begin
            for (int c = 0; c < 2; c++) begin
              if (sel_b == c[0]) begin
                if (mode_sel[c]) mode_next[2*c+1] = item.write_data;
                else mode_next[2*c] = item.write_data;
                mode_sel_next[c] = ~mode_sel[c];
              end
            end
          end
          REG_CR_A, REG_CR_B: begin
            tx_refresh = 1'b1;
            for (int c = 0; c < 2; c++) begin
              if (sel_b == c[0]) begin
                if (item.write_data[CM_ETX]) command_next[c][CM_ETX] = 1'b1;
                else if (item.write_data[CM_DTX]) command_next[c][CM_ETX] = 1'b0;
                if (item.write_data[CM_ERX]) command_next[c][CM_ERX] = 1'b1;
                else if (item.write_data[CM_DRX]) command_next[c][CM_ERX] = 1'b0;
                unique case (misc)
                  MISC_RESET_MR: mode_sel_next[c] = 1'b0;
                  MISC_RESET_RX: begin
                    command_next[c][CM_ERX] = 1'b0;
                    status_next[c][ST_RXR]  = 1'b0;
                  end
                  MISC_RESET_TX: status_next[c][ST_TXR] = 1'b0;
                  MISC_RESET_ER: status_next[c] = status[c] & ~ST_ERR_MASK;
                  default: ;
                endcase
              end
            end
          end
          REG_BUF_A, REG_BUF_B: begin
            tx_refresh = 1'b1;
            for (int c = 0; c < 2; c++) begin
              if (sel_b == c[0]) begin
                rbuf_next[c] = item.write_data;
                status_next[c][ST_RXR] = 1'b1;
                int_status_next = int_status | RX_INT_BIT[c];
              end
            end
          end
          REG_ACR: aux_control_next = item.write_data;
          REG_ISR: int_mask_next = item.write_data;
          REG_CTU: begin
            counter_preset_next = {item.write_data, counter_preset[7:0]};
            counter_value_next  = {item.write_data, counter_value[7:0]};
          end
          REG_CTL: begin
            counter_preset_next = {counter_preset[15:8], item.write_data};
            counter_value_next  = {counter_value[15:8], item.write_data};
          end
          default: ;
        endcase
      end

      ACT_TICK: begin
        if (counter_running) begin
          if (counter_value <= counter_step) begin
            int_status_next[IS_CRI] = 1'b1;
            counter_value_next      = counter_preset;
            counter_running_next    = 1'b0;
            if (item.pir9_enable) res.irq_action = IRQ_RAISE;
          end else begin
            counter_value_next = counter_value - counter_step;
          end
        end
        // A received character is only taken while transmitter A is on.
        if (item.rx_valid && command[0][CM_ETX]) begin
          rbuf_next[0] = item.rx_char;
          status_next[0][ST_RXR] = 1'b1;
          int_status_next = int_status_next | RX_INT_BIT[0];
          for (int c = 0; c < 2; c++) begin
            if (command[c][CM_ERX]) begin
              if (!status_next[c][ST_RXR]) begin
                rbuf_next[c] = item.rx_char;
                status_next[c][ST_RXR] = 1'b1;
                int_status_next = int_status_next | RX_INT_BIT[c];
              end
            end else begin
              status_next[c][ST_RXR] = 1'b0;
              int_status_next = int_status_next & ~RX_INT_BIT[c];
            end
          end
        end
      end

      default: ;
    endcase

    // Transmit status follows the transmit enables after command and buffer writes.
    if (tx_refresh) begin
      for (int c = 0; c < 2; c++) begin
        status_next[c][ST_TXR] = command_next[c][CM_ETX];
        status_next[c][ST_TXE] = command_next[c][CM_ETX];
        if (command_next[c][CM_ETX]) int_status_next = int_status_next | TX_INT_BIT[c];
        else int_status_next = int_status_next & ~TX_INT_BIT[c];
      end
      res.irq_action = |(int_status_next & int_mask) ? IRQ_RAISE : IRQ_LOWER;
      if (item.reg_addr == REG_BUF_A && command_next[0][CM_ETX]) begin
        res.tx_valid = 1'b1;
        res.tx_char  = item.write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= '{default: '0};
      mode_sel        <= '0;
      status          <= '{default: '0};
      command         <= '{default: '0};
      rbuf            <= '{default: '0};
      int_status      <= '0;
      int_mask        <= '0;
      aux_control     <= '0;
      counter_preset  <= '0;
      counter_value   <= '0;
      counter_running <= 1'b0;
    end else if (fire) begin
      mode            <= mode_next;
      mode_sel        <= mode_sel_next;
      status          <= status_next;
      command         <= command_next;
      rbuf            <= rbuf_next;
      int_status      <= int_status_next;
      int_mask        <= int_mask_next;
      aux_control     <= aux_control_next;
      counter_preset  <= counter_preset_next;
      counter_value   <= counter_value_next;
      counter_running <= counter_running_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/dual_uart_register_model_unit.sv
// Top level of the dual UART register block: input register, update logic, result register.
//
//   Channel  Direction  Handshake          Carries
//   req      in         valid / ready      action, reg_addr, write_data, rx_*, pir9_enable
//   rsp      out        valid / ready      read_data, irq_action, tx_valid, tx_char
//   APB      in/out     psel/penable       counter_step at byte address 0
//
// One item is accepted every cycle unless the result side stalls. An item is captured in
// the input register at the accepting edge; its result is loaded into the result register
// as the item moves on. All state updates of an item happen in that single step.
// Reset (rst, synchronous) clears all UART state and sets counter_step to 1.
// When the result register is full and not taken, the input register holds its item
// and req.ready drops; no transfer is lost or repeated.
`default_nettype none
module dual_uart_register_model_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  dur_item_if.sink                         req,
  dur_result_if.source                     rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dur_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dur_pkg::PDATA_W-1:0] pwdata,
  output logic      [dur_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import dur_pkg::*;

  logic              in_valid;
  item_t             in_item;
  logic              out_valid;
  result_t           out_res;
  result_t           res;
  logic              advance;
  logic [CNT_W-1:0]  counter_step;

  // The held item moves on when the result register is empty or being emptied.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.action      <= req.action;
      in_item.reg_addr    <= req.reg_addr;
      in_item.write_data  <= req.write_data;
      in_item.rx_valid    <= req.rx_valid;
      in_item.rx_char     <= req.rx_char;
      in_item.pir9_enable <= req.pir9_enable;
    end
  end

  dur_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .counter_step (counter_step)
  );

  dur_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .item         (in_item),
    .counter_step (counter_step),
    .res          (res)
  );

  // Result register: filled as the item is processed, emptied by a transfer on rsp.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_res.read_data;
  assign rsp.irq_action = out_res.irq_action;
  assign rsp.tx_valid   = out_res.tx_valid;
  assign rsp.tx_char    = out_res.tx_char;

`ifndef SYNTHESIS
  // A transmitted byte only comes from a buffer write, which always drives the interrupt.
  a_tx_from_write: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.tx_valid) |-> (rsp.irq_action != IRQ_NONE && rsp.read_data == '0))
    else $error("transmit result without a buffer write");

  a_tx_char_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.tx_valid) |-> (rsp.tx_char == '0))
    else $error("tx_char set without tx_valid");

  // A held item that cannot move on stays put.
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item)))
    else $error("stalled item lost or changed");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item produced no result");
`endif
endmodule
`default_nettype wire

>>> test/dual_uart_register_model_unit_checker.sv
// Checker that predicts every result of the dual UART block and compares it with the DUT.
`timescale 1ns / 100ps
module dual_uart_register_model_unit_checker
  import dur_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  dur_item_if                      req,
  dur_result_if                    rsp,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic                pready,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output int unsigned              mismatches,
  output int unsigned              outstanding,
  output int unsigned              results_seen,
  output int unsigned              bytes_sent,
  output int unsigned              expiries
);

  localparam int unsigned MAX_REPORTS = 10;

  // Mirror of the block's register state.
  logic [BYTE_W-1:0] mode_reg [4];
  logic              mode_sel [2];
  logic [BYTE_W-1:0] status   [2];
  logic [BYTE_W-1:0] command  [2];
  logic [BYTE_W-1:0] rx_hold  [2];
  logic [BYTE_W-1:0] isr;
  logic [BYTE_W-1:0] imr;
  logic [BYTE_W-1:0] acr;
  logic [CNT_W-1:0]  preset;
  logic [CNT_W:0]    count;
  logic              running;
  logic [CNT_W-1:0]  step;

  result_t due_results [$];

  function automatic logic [BYTE_W-1:0] mode_access(input int ch, input bit wr,
                                                    input logic [BYTE_W-1:0] wd);
    int slot;
    logic [BYTE_W-1:0] old;
    slot = 2 * ch + int'(mode_sel[ch]);
    old = mode_reg[slot];
    if (wr) mode_reg[slot] = wd;
    mode_sel[ch] = ~mode_sel[ch];
    return old;
  endfunction

  function automatic logic [RDATA_W-1:0] take_rx(input int ch);
    logic [RDATA_W-1:0] d;
    d = {status[ch], rx_hold[ch]};
    status[ch][ST_RXR] = 1'b0;
    isr = isr & ~RX_INT_BIT[ch];
    return d;
  endfunction

  function automatic void load_rx(input int ch, input logic [BYTE_W-1:0] v);
    rx_hold[ch] = v;
    status[ch][ST_RXR] = 1'b1;
    isr = isr | RX_INT_BIT[ch];
  endfunction

  function automatic void apply_command(input int ch, input logic [BYTE_W-1:0] v);
    if (v[CM_ETX]) command[ch][CM_ETX] = 1'b1;
    else if (v[CM_DTX]) command[ch][CM_ETX] = 1'b0;
    if (v[CM_ERX]) command[ch][CM_ERX] = 1'b1;
    else if (v[CM_DRX]) command[ch][CM_ERX] = 1'b0;
    case (v[6:4])
      MISC_RESET_MR: mode_sel[ch] = 1'b0;
      MISC_RESET_RX: begin
        command[ch][CM_ERX] = 1'b0;
        status[ch][ST_RXR] = 1'b0;
      end
      MISC_RESET_TX: status[ch][ST_TXR] = 1'b0;
      MISC_RESET_ER: status[ch] = status[ch] & ~ST_ERR_MASK;
      default: ;
    endcase
  endfunction

  // Transmit ready/empty and the transmit interrupt bits track the enables.
  function automatic logic [IRQ_W-1:0] refresh_tx();
    for (int ch = 0; ch < 2; ch++) begin
      status[ch][ST_TXR] = command[ch][CM_ETX];
      status[ch][ST_TXE] = command[ch][CM_ETX];
      if (command[ch][CM_ETX]) isr = isr | TX_INT_BIT[ch];
      else isr = isr & ~TX_INT_BIT[ch];
    end
    return ((isr & imr) != '0) ? IRQ_RAISE : IRQ_LOWER;
  endfunction

  // Applies one item to the mirrored state and returns the result it must produce.
  function automatic result_t apply_item(input item_t it);
    result_t r;
    r = '0;
    case (it.action)
      ACT_READ: begin
        case (it.reg_addr)
          REG_MR_A:  r.read_data = RDATA_W'(mode_access(0, 1'b0, '0));
          REG_SR_A: begin
            r.read_data = RDATA_W'(status[0]);
            status[0][ST_RXR] = 1'b0;
          end
          REG_BUF_A: r.read_data = take_rx(0);
          REG_ISR:   r.read_data = RDATA_W'(isr);
          REG_MR_B:  r.read_data = RDATA_W'(mode_access(1, 1'b0, '0));
          REG_SR_B:  r.read_data = RDATA_W'(status[1]);
          REG_BUF_B: r.read_data = take_rx(1);
          REG_START: running = 1'b1;
          REG_STOP: begin
            running = 1'b0;
            isr[IS_CRI] = 1'b0;
          end
          default: ;
        endcase
      end
      ACT_WRITE: begin
        case (it.reg_addr)
          REG_MR_A: void'(mode_access(0, 1'b1, it.write_data));
          REG_MR_B: void'(mode_access(1, 1'b1, it.write_data));
          REG_CR_A: begin
            apply_command(0, it.write_data);
            r.irq_action = refresh_tx();
          end
          REG_CR_B: begin
            apply_command(1, it.write_data);
            r.irq_action = refresh_tx();
          end
          REG_BUF_A: begin
            load_rx(0, it.write_data);
            r.irq_action = refresh_tx();
            if (command[0][CM_ETX]) begin
              r.tx_valid = 1'b1;
              r.tx_char = rx_hold[0];
            end
          end
          REG_BUF_B: begin
            load_rx(1, it.write_data);
            r.irq_action = refresh_tx();
          end
          REG_ACR: acr = it.write_data;
          REG_ISR: imr = it.write_data;
          REG_CTU: begin
            preset[15:8] = it.write_data;
            count = {9'd0, count[7:0]} | {1'b0, it.write_data, 8'd0};
          end
          REG_CTL: begin
            preset[7:0] = it.write_data;
            count = {1'b0, count[15:8], it.write_data};
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (running) begin
          if (count <= {1'b0, step}) begin
            isr[IS_CRI] = 1'b1;
            count = {1'b0, preset};
            running = 1'b0;
            expiries++;
            if (it.pir9_enable) r.irq_action = IRQ_RAISE;
          end else begin
            count = count - {1'b0, step};
          end
        end
        // A character only gets in while transmitter A is enabled.
        if (it.rx_valid && command[0][CM_ETX]) begin
          load_rx(0, it.rx_char);
          for (int ch = 0; ch < 2; ch++) begin
            if (command[ch][CM_ERX]) begin
              if (!status[ch][ST_RXR]) load_rx(ch, it.rx_char);
            end else begin
              status[ch][ST_RXR] = 1'b0;
              isr = isr & ~RX_INT_BIT[ch];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) mode_reg[i] = '0;
      for (int ch = 0; ch < 2; ch++) begin
        mode_sel[ch] = 1'b0;
        status[ch]   = '0;
        command[ch]  = '0;
        rx_hold[ch]  = '0;
      end
      isr     = '0;
      imr     = '0;
      acr     = '0;
      preset  = '0;
      count   = '0;
      running = 1'b0;
      step    = COUNTER_STEP_RST;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CFG_COUNTER_STEP)
        step = pwdata[CNT_W-1:0];
      // Results are retired before new items are queued, so a result can never
      // be matched against an item that was accepted at the same edge.
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (rsp.tx_valid === 1'b1) bytes_sent++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with none pending: rd=%h irq=%0d tx=%b/%h", $realtime,
                     rsp.read_data, rsp.irq_action, rsp.tx_valid, rsp.tx_char);
        end else begin
          want = due_results.pop_front();
          if (rsp.read_data !== want.read_data || rsp.irq_action !== want.irq_action ||
              rsp.tx_valid !== want.tx_valid || rsp.tx_char !== want.tx_char) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result %0d differs: exp rd=%h irq=%0d tx=%b/%h, got rd=%h irq=%0d tx=%b/%h",
                       $realtime, results_seen, want.read_data, want.irq_action,
                       want.tx_valid, want.tx_char, rsp.read_data, rsp.irq_action,
                       rsp.tx_valid, rsp.tx_char);
          end
        end
      end
      if (req.valid && req.ready)
        due_results.push_back(apply_item({req.action, req.reg_addr, req.write_data,
                                          req.rx_valid, req.rx_char, req.pir9_enable}));
    end
    outstanding <= due_results.size();
  end

endmodule

>>> test/dual_uart_register_model_unit_tb.sv
// Top of the dual UART block testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 100ps
module dual_uart_register_model_unit_tb;
  import dur_pkg::*;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 12;
  // The DUT has a two-stage pipeline, so the settle time lets any stray result show up.
  localparam int SETTLE_CYCLES    = 6;
  localparam int HOLD_OFF_CYCLES  = 60;
  localparam int END_LIMIT        = 5000;
  localparam int RUN_LIMIT_NS     = 3_000_000;

  // Codes that the package does not name: the unused item kind and three register
  // numbers that are not decoded.
  localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;
  localparam logic [ADDR_W-1:0]   REG_IGNORED  = 5'd17;
  localparam logic [ADDR_W-1:0]   REG_TOP      = 5'd31;
  localparam logic [ADDR_W-1:0]   REG_SPARE    = 5'd12;

  // Each random phase runs with its own counter step; 0 and the maximum are the extremes.
  localparam int NUM_PHASES = 4;
  localparam logic [CNT_W-1:0] PHASE_STEP  [NUM_PHASES] = '{16'd3, 16'hFFFF, 16'd0, 16'd1};
  localparam int               PHASE_ITEMS [NUM_PHASES] = '{110, 100, 80, 130};

  // Registers that the random part picks from, so that most traffic hits decoded ones.
  localparam logic [ADDR_W-1:0] READ_REGS [9] = '{REG_MR_A, REG_SR_A, REG_BUF_A, REG_ISR,
    REG_MR_B, REG_SR_B, REG_BUF_B, REG_START, REG_STOP};
  localparam logic [ADDR_W-1:0] WRITE_REGS [10] = '{REG_MR_A, REG_CR_A, REG_BUF_A, REG_ACR,
    REG_ISR, REG_CTU, REG_CTL, REG_MR_B, REG_CR_B, REG_BUF_B};

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned bytes_sent;
  int unsigned expiries;
  int unsigned items_sent = 0;

  // Flags of the stimulus; quiet_tail and hold_request are also read by the result sink.
  bit quiet_tail   = 1'b0;
  bit hold_request = 1'b0;
  bit send_calm    = 1'b0;

  dur_item_if   req_if ();
  dur_result_if rsp_if ();

  dual_uart_register_model_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dual_uart_register_model_unit_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .req          (req_if),
    .rsp          (rsp_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .bytes_sent   (bytes_sent),
    .expiries     (expiries)
  );

  always #HALF_PERIOD clk = ~clk;

  // Offers one item and returns at the edge where its transfer happens. A random
  // gap may come first, except in calm stretches and in the tail.
  task automatic offer(input item_t it);
    if (!quiet_tail && !send_calm && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= it.action;
    req_if.reg_addr    <= it.reg_addr;
    req_if.write_data  <= it.write_data;
    req_if.rx_valid    <= it.rx_valid;
    req_if.rx_char     <= it.rx_char;
    req_if.pir9_enable <= it.pir9_enable;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
  endtask

  task automatic post(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                      input logic [BYTE_W-1:0] wd, input logic rxv,
                      input logic [BYTE_W-1:0] rxc, input logic pir9);
    offer('{act, addr, wd, rxv, rxc, pir9});
  endtask

  // Builds one random item. Most items are decoded reads, writes and ticks; a few
  // are pure noise with any kind and any register number.
  function automatic item_t make_item();
    item_t it;
    int unsigned pick;
    it.action      = ACT_TICK;
    it.reg_addr    = ADDR_W'($urandom_range(0, 31));
    it.write_data  = BYTE_W'($urandom_range(0, 255));
    it.rx_valid    = 1'($urandom_range(0, 1));
    it.rx_char     = BYTE_W'($urandom_range(0, 255));
    it.pir9_enable = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.action = ACTION_W'($urandom_range(0, 3));
    end else if (pick < 40) begin
      it.action = ACT_TICK;
    end else if (pick < 70) begin
      it.action   = ACT_READ;
      it.reg_addr = READ_REGS[$urandom_range(0, 8)];
    end else begin
      it.action   = ACT_WRITE;
      it.reg_addr = WRITE_REGS[$urandom_range(0, 9)];
      // A short preset lets a started counter expire within a few ticks.
      if (it.reg_addr == REG_CTU && $urandom_range(0, 7) != 0) it.write_data = '0;
      if (it.reg_addr == REG_CTL && $urandom_range(0, 3) != 0)
        it.write_data = BYTE_W'($urandom_range(0, 12));
      // Received characters only get in while transmitter A is enabled, so keep
      // it enabled most of the time.
      if (it.reg_addr == REG_CR_A && $urandom_range(0, 3) != 0) it.write_data[CM_ETX] = 1'b1;
    end
    return it;
  endfunction

  // One APB write: a setup cycle, then the access cycle that completes with pready.
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stops offering and waits until every predicted result has come back. The extra
  // edge first lets the checker count the last accepted item.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink. It stalls in random bursts, with calm stretches between them, and
  // once, on request of the stimulus, holds ready low for a long hold-off so the
  // pipeline fills up and the DUT has to drop req.ready.
  initial begin : result_sink
    int unsigned stall_left;
    bit calm;
    stall_left = 0;
    calm = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rsp_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && !calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 16);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
      if ($urandom_range(0, 49) == 0) calm = !calm;
    end
  end

  initial begin : stimulus
    int waited;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_if.valid       <= 1'b0;
    req_if.action      <= ACT_READ;
    req_if.reg_addr    <= '0;
    req_if.write_data  <= '0;
    req_if.rx_valid    <= 1'b0;
    req_if.rx_char     <= '0;
    req_if.pir9_enable <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_write(CFG_COUNTER_STEP, 16'd1);

    // Directed part. The mode pointer must toggle once per access on both channels.
    post(ACT_READ,  REG_MR_A,  8'h00, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_MR_A,  8'hFF, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_MR_B,  8'hA5, 1'b0, 8'h00, 1'b0);
    post(ACT_READ,  REG_MR_B,  8'h00, 1'b0, 8'h00, 1'b0);
    // Unmask everything, enable channel A both ways and send a byte through it.
    post(ACT_WRITE, REG_ISR,   8'hFF, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_CR_A,  8'h05, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_BUF_A, 8'h5A, 1'b0, 8'h00, 1'b0);
    post(ACT_READ,  REG_SR_A,  8'h00, 1'b0, 8'h00, 1'b0);
    post(ACT_READ,  REG_BUF_A, 8'h00, 1'b0, 8'h00, 1'b0);
    // A received character lands on both channels once receiver B is on.
    post(ACT_WRITE, REG_CR_B,  8'h01, 1'b0, 8'h00, 1'b0);
    post(ACT_TICK,  REG_TOP,   8'hFF, 1'b1, 8'hFF, 1'b1);
    post(ACT_READ,  REG_BUF_B, 8'h00, 1'b0, 8'h00, 1'b0);
    // Counter loaded with 2 and started: it expires on the second tick.
    post(ACT_WRITE, REG_CTL,   8'h02, 1'b0, 8'h00, 1'b0);
    post(ACT_READ,  REG_START, 8'h00, 1'b0, 8'h00, 1'b0);
    post(ACT_TICK,  REG_MR_A,  8'h00, 1'b0, 8'h00, 1'b1);
    post(ACT_TICK,  REG_MR_A,  8'h00, 1'b0, 8'h00, 1'b1);
    post(ACT_READ,  REG_ISR,   8'h00, 1'b0, 8'h00, 1'b0);
    post(ACT_READ,  REG_STOP,  8'h00, 1'b0, 8'h00, 1'b0);
    // Miscellaneous commands: receiver reset with both disables, mode pointer reset,
    // transmitter reset, error reset and an unused code with both tx bits set.
    post(ACT_WRITE, REG_CR_A,  8'h2A, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_CR_B,  8'h10, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_CR_A,  8'h30, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_CR_B,  8'h4C, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_CR_A,  8'h7F, 1'b0, 8'h00, 1'b0);
    // Auxiliary control, then items that must leave the state alone: an undecoded
    // write, undecoded reads and the unused item kind.
    post(ACT_WRITE, REG_ACR,   8'hFF, 1'b0, 8'h00, 1'b0);
    post(ACT_WRITE, REG_TOP,   8'hFF, 1'b1, 8'hFF, 1'b1);
    post(ACT_READ,  REG_IGNORED, 8'h00, 1'b0, 8'h00, 1'b0);
    post(ACT_READ,  REG_SPARE, 8'h00, 1'b0, 8'h00, 1'b0);
    post(ACT_UNUSED, REG_TOP,  8'hFF, 1'b1, 8'hFF, 1'b1);
    post(ACT_WRITE, REG_BUF_B, 8'h00, 1'b0, 8'h00, 1'b0);
    drain();

    // Random phases, each with its own counter step written while the DUT is idle.
    // The first one opens with the long hold-off on the result side; the last one
    // runs without any idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_write(CFG_COUNTER_STEP, PHASE_STEP[p]);
      if (p == 0) hold_request = 1'b1;
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      for (int n = 0; n < PHASE_ITEMS[p]; n++) offer(make_item());
      if (p != NUM_PHASES - 1) drain();
    end

    // End of stimulus: wait for the last results, with a limit, then let the pipeline settle.
    req_if.valid <= 1'b0;
    @(posedge clk);
    for (waited = 0; waited < END_LIMIT && outstanding != 0; waited++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items over %0d counter step settings; %0d results checked,",
             items_sent, NUM_PHASES + 1, results_seen);
    $display("%0d bytes sent on channel A, %0d counter expiries, %0d mismatches.",
             bytes_sent, expiries, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[dual_uart_register_model_unit] OK");
    end else begin
      $display("[dual_uart_register_model_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every gap at its longest.
  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("Run did not complete in time.");
    $display("[dual_uart_register_model_unit] ERROR");
    $finish;
  end

endmodule
